/* src/fsla_pkg.sv */
// Shared types and constants for the free-list slot allocator.
// No dependencies; imported by fsla_queue and the top level.
package fsla_pkg;

  // Fixed field widths of the stream words
  localparam int unsigned SlotW  = 6;
  localparam int unsigned SizeW  = 7;
  localparam int unsigned InDataW  = 24;
  localparam int unsigned OutDataW = 16;

  // Operation issued to the free-list queue unit, one per cycle
  typedef enum logic [1:0] {
    QOP_NONE  = 2'd0,
    QOP_CLEAR = 2'd1,
    QOP_PUSH  = 2'd2,
    QOP_POP   = 2'd3
  } queue_op_e;

  typedef struct packed {
    queue_op_e        op;
    logic [SlotW-1:0] data;
  } queue_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

/* src/fsla_queue.sv */
// FIFO free list: slot-number memory with head/tail pointers and fill count.
// Executes one command (clear, push or pop) per cycle. Depends on fsla_pkg.
module fsla_queue #(
  parameter int unsigned SLOT_COUNT = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  fsla_pkg::queue_cmd_t        cmd_i,
  output fsla_pkg::queue_status_t     status_o,
  output logic [fsla_pkg::SlotW-1:0]  rd_data_o
);
  import fsla_pkg::*;

  localparam int unsigned AddrW = $clog2(SLOT_COUNT);
  localparam int unsigned CntW  = $clog2(SLOT_COUNT + 1);
  localparam logic [AddrW-1:0] LastIdx = AddrW'(SLOT_COUNT - 1);
  localparam logic [CntW-1:0]  Depth   = CntW'(SLOT_COUNT);

  logic [SlotW-1:0] mem [SLOT_COUNT];
  logic [AddrW-1:0] head_q, head_d, tail_q, tail_d;
  logic [CntW-1:0]  count_q, count_d;
  logic [SlotW-1:0] rd_data_q;
  logic             full, empty, do_push, do_pop;

  assign full    = (count_q == Depth);
  assign empty   = (count_q == '0);
  assign do_push = (cmd_i.op == QOP_PUSH) && !full;
  assign do_pop  = (cmd_i.op == QOP_POP) && !empty;

  // Pointer and count update
  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    unique case (cmd_i.op)
      QOP_CLEAR: begin
        head_d  = '0;
        tail_d  = '0;
        count_d = '0;
      end
      QOP_PUSH: begin
        if (do_push) begin
          tail_d  = (tail_q == LastIdx) ? '0 : tail_q + 1'b1;
          count_d = count_q + 1'b1;
        end
      end
      QOP_POP: begin
        if (do_pop) begin
          head_d  = (head_q == LastIdx) ? '0 : head_q + 1'b1;
          count_d = count_q - 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  // Single-port memory: write on push, registered read on pop
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem[tail_q] <= cmd_i.data;
    end else if (do_pop) begin
      rd_data_q <= mem[head_q];
    end
  end

  assign status_o.full  = full;
  assign status_o.empty = empty;
  assign rd_data_o      = rd_data_q;

endmodule

/* src/fifo_free_list_slot_allocator_unit.sv */
// Top level of the free-list slot allocator: stream ports, sequencer,
// high-water counter and output register. Depends on fsla_pkg, fsla_queue.
//
// Usage:
//   Slave stream carries one operation per word: an optional start (clear
//   free list and high-water count), then up to three slot releases
//   (left, right, other) pushed in that order onto a FIFO free list.
//   Master stream returns one word per operation: the assigned slot (oldest
//   free entry, else a freshly created one), the buffer size so far, and
//   the exhausted and overflow flags.
//   Each word passes through the accept step, three push steps and one pop
//   step through the single-ported free-list memory, and a final step for
//   its registered read data. The input is not ready during that time; the
//   result enters the output register from that final step once it is free.
//   The output register holds a result while the receiver stalls; the next
//   word is accepted meanwhile, and the sequencer waits in its last step
//   only if the previous result has not yet been taken.
//   Reset empties the free list and clears the high-water count; the list
//   memory itself is not cleared and needs no clearing pass.
module fifo_free_list_slot_allocator_unit #(
  parameter int unsigned SLOT_COUNT = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [0] start_req, [1] left_valid, [7:2] left_slot, [8] right_valid,
  // [14:9] right_slot, [15] other_valid, [21:16] other_slot, [23:22] zero
  input  logic [fsla_pkg::InDataW-1:0]   s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [5:0] slot, [12:6] buffer_size, [13] exhausted, [14] overflow, [15] zero
  output logic [fsla_pkg::OutDataW-1:0]  m_axis_tdata
);
  import fsla_pkg::*;

  localparam int unsigned CntW = $clog2(SLOT_COUNT + 1);
  localparam logic [CntW-1:0] MaxCreated = CntW'(SLOT_COUNT);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LEFT,
    S_RIGHT,
    S_OTHER,
    S_ALLOC,
    S_DONE
  } state_e;

  state_e           state_q;
  logic [CntW-1:0]  created_q;
  logic [2:0]       rel_valid_q;
  logic [SlotW-1:0] rel_slot_q [3];
  logic             from_queue_q, exhausted_q, overflow_q;
  logic [SlotW-1:0] slot_q;
  logic             m_valid_q;
  logic [SlotW-1:0] m_slot_q;
  logic [SizeW-1:0] m_size_q;
  logic             m_exh_q, m_ovf_q;

  queue_cmd_t       qcmd;
  queue_status_t    qstat;
  logic [SlotW-1:0] q_rd_data;
  logic             s_accept, out_free;
  logic [1:0]       push_idx;

  assign s_axis_tready = (state_q == S_IDLE);
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;

  // Which release the current push step handles
  always_comb begin
    unique case (state_q)
      S_RIGHT: push_idx = 2'd1;
      S_OTHER: push_idx = 2'd2;
      default: push_idx = 2'd0;
    endcase
  end

  // Command to the queue unit
  always_comb begin
    qcmd.op   = QOP_NONE;
    qcmd.data = rel_slot_q[push_idx];
    unique case (state_q)
      S_IDLE: if (s_accept && s_axis_tdata[0]) qcmd.op = QOP_CLEAR;
      S_LEFT, S_RIGHT, S_OTHER: if (rel_valid_q[push_idx]) qcmd.op = QOP_PUSH;
      S_ALLOC: if (!qstat.empty) qcmd.op = QOP_POP;
      default: ;
    endcase
  end

  fsla_queue #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (qcmd),
    .status_o  (qstat),
    .rd_data_o (q_rd_data)
  );

  // Sequencer, high-water count and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      created_q <= '0;
      m_valid_q <= 1'b0;
    end else begin
      if (m_valid_q && m_axis_tready && (state_q != S_DONE)) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (s_accept) begin
            if (s_axis_tdata[0]) created_q <= '0;
            state_q <= S_LEFT;
          end
        end
        S_LEFT:  state_q <= S_RIGHT;
        S_RIGHT: state_q <= S_OTHER;
        S_OTHER: state_q <= S_ALLOC;
        S_ALLOC: begin
          if (qstat.empty && (created_q != MaxCreated)) begin
            created_q <= created_q + 1'b1;
          end
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            m_valid_q <= 1'b1;
            state_q   <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Per-word working registers and result payload
  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      rel_valid_q   <= {s_axis_tdata[15], s_axis_tdata[8], s_axis_tdata[1]};
      rel_slot_q[0] <= s_axis_tdata[7:2];
      rel_slot_q[1] <= s_axis_tdata[14:9];
      rel_slot_q[2] <= s_axis_tdata[21:16];
      overflow_q    <= 1'b0;
    end
    if (qcmd.op == QOP_PUSH && qstat.full) begin
      overflow_q <= 1'b1;
    end
    if (state_q == S_ALLOC) begin
      from_queue_q <= !qstat.empty;
      exhausted_q  <= qstat.empty && (created_q == MaxCreated);
      slot_q       <= (qstat.empty && (created_q != MaxCreated)) ?
                      SlotW'(created_q) : '0;
    end
    if (state_q == S_DONE && out_free) begin
      m_slot_q <= from_queue_q ? q_rd_data : slot_q;
      m_size_q <= SizeW'(created_q);
      m_exh_q  <= exhausted_q;
      m_ovf_q  <= overflow_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {1'b0, m_ovf_q, m_exh_q, m_size_q, m_slot_q};

  // A result appears only out of the last sequencer step
  a_valid_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> $past(state_q == S_DONE))
    else $error("result raised outside the final step");

  // Exhausted results always carry slot zero
  a_exh_slot_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && m_exh_q) |-> (m_slot_q == '0))
    else $error("exhausted result with nonzero slot");

  // High-water count never passes the number of slots
  a_created_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    created_q <= MaxCreated)
    else $error("created count beyond slot count");

  // A held result is not lost while the receiver stalls
  a_hold_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && !m_axis_tready) |=> m_valid_q && $stable(m_axis_tdata))
    else $error("stalled result changed");

endmodule

/* sim/fifo_free_list_slot_allocator_unit_test.sv */
`timescale 1ns / 1ps
// Self-checking testbench for fifo_free_list_slot_allocator_unit: directed and random
// operations, each grant predicted by an in-bench free-list model. Depends on fsla_pkg.
module fifo_free_list_slot_allocator_unit_test;
  import fsla_pkg::*;

  localparam int unsigned SLOTS = 64;

  typedef struct packed {
    logic             other_valid;
    logic [SlotW-1:0] other_slot;
    logic             right_valid;
    logic [SlotW-1:0] right_slot;
    logic             left_valid;
    logic [SlotW-1:0] left_slot;
    logic             start_req;
  } alloc_op_t;

  typedef struct packed {
    logic [SlotW-1:0] slot;
    logic [SizeW-1:0] buffer_size;
    logic             exhausted;
    logic             overflow;
  } grant_t;

  // Release mix of a random burst
  typedef enum logic [1:0] {
    MIX_GROW = 2'd0,
    MIX_EVEN = 2'd1,
    MIX_FILL = 2'd2
  } burst_mix_e;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;

  fifo_free_list_slot_allocator_unit #(
    .SLOT_COUNT(SLOTS)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // Free-list model state
  logic [SlotW-1:0] free_ring [SLOTS];
  int unsigned      ring_head;
  int unsigned      ring_tail;
  int unsigned      ring_count;
  int unsigned      created;

  grant_t      pending_grants[$];
  int unsigned src_idle_pct;
  int unsigned sink_stall_pct;
  int unsigned mismatches;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Watchdog
  initial begin
    #5ms;
    $display("tb: failure");
    $finish;
  end

  // Queue one release; false when the list is full and the slot is dropped
  function automatic bit release_slot(input logic [SlotW-1:0] s);
    if (ring_count >= SLOTS) return 1'b0;
    free_ring[ring_tail] = s;
    ring_tail = (ring_tail + 1) % SLOTS;
    ring_count++;
    return 1'b1;
  endfunction

  // Grant for one operation, updating the model
  function automatic grant_t grant_slot(input alloc_op_t op);
    grant_t g;
    g = '0;
    if (op.start_req) begin
      ring_head  = 0;
      ring_tail  = 0;
      ring_count = 0;
      created    = 0;
    end
    if (op.left_valid && !release_slot(op.left_slot)) g.overflow = 1'b1;
    if (op.right_valid && !release_slot(op.right_slot)) g.overflow = 1'b1;
    if (op.other_valid && !release_slot(op.other_slot)) g.overflow = 1'b1;
    if (ring_count > 0) begin
      g.slot    = free_ring[ring_head];
      ring_head = (ring_head + 1) % SLOTS;
      ring_count--;
    end else if (created < SLOTS) begin
      g.slot = created[SlotW-1:0];
      created++;
    end else begin
      g.exhausted = 1'b1;
    end
    g.buffer_size = created[SizeW-1:0];
    return g;
  endfunction

  function automatic alloc_op_t make_op(input bit st, input bit lv, input int unsigned ls,
                                        input bit rv, input int unsigned rs,
                                        input bit ov, input int unsigned os);
    alloc_op_t op;
    op.start_req   = st;
    op.left_valid  = lv;
    op.left_slot   = ls[SlotW-1:0];
    op.right_valid = rv;
    op.right_slot  = rs[SlotW-1:0];
    op.other_valid = ov;
    op.other_slot  = os[SlotW-1:0];
    return op;
  endfunction

  // Send one operation word and record its expected grant on acceptance
  task automatic send_op(input alloc_op_t op);
    if ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < src_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, op.other_slot, op.other_valid, op.right_slot, op.right_valid,
                      op.left_slot, op.left_valid, op.start_req};
    do @(posedge clk_i); while (!s_axis_tready);
    pending_grants.insert(pending_grants.size(), grant_slot(op));
  endtask

  task automatic report_field(input string name, input int unsigned exp_v,
                              input int unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_v, act_v);
      mismatches++;
    end
  endtask

  // Result checker and receiver stall
  always @(posedge clk_i) begin
    grant_t exp_g;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_grants.size() == 0) begin
        $display("%0t: unexpected result word: expected none, actual %h", $time,
                 m_axis_tdata);
        mismatches++;
      end else begin
        exp_g = pending_grants.pop_front();
        report_field("slot", 32'(exp_g.slot), 32'(m_axis_tdata[5:0]));
        report_field("buffer_size", 32'(exp_g.buffer_size), 32'(m_axis_tdata[12:6]));
        report_field("exhausted", 32'(exp_g.exhausted), 32'(m_axis_tdata[13]));
        report_field("overflow", 32'(exp_g.overflow), 32'(m_axis_tdata[14]));
      end
    end
    m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // Extremes of every field, each release alone and together, start handling
  task automatic test_directed();
    send_op(make_op(1, 0, 0, 0, 0, 0, 0));
    send_op(make_op(0, 0, 0, 0, 0, 0, 0));
    send_op(make_op(0, 1, 0, 0, 0, 0, 0));
    send_op(make_op(0, 0, 0, 1, 1, 0, 0));
    send_op(make_op(0, 0, 0, 0, 0, 1, 63));
    send_op(make_op(0, 1, 63, 1, 0, 1, 63));
    send_op(make_op(0, 1, 42, 1, 21, 1, 42));
    send_op(make_op(0, 1, 21, 1, 42, 1, 21));
    send_op(make_op(0, 0, 63, 0, 63, 0, 63));
    send_op(make_op(0, 0, 0, 0, 0, 0, 0));
    send_op(make_op(0, 1, 5, 1, 5, 0, 0));
    send_op(make_op(1, 1, 63, 1, 62, 1, 61));
    send_op(make_op(0, 0, 0, 0, 0, 0, 0));
    send_op(make_op(0, 0, 0, 0, 0, 0, 0));
    send_op(make_op(0, 0, 0, 0, 0, 0, 0));
    send_op(make_op(1, 0, 42, 0, 21, 0, 42));
    send_op(make_op(0, 1, 1, 0, 0, 1, 2));
    send_op(make_op(1, 0, 0, 0, 0, 0, 0));
  endtask

  // Fill the list past its capacity, then drain it across the index wrap
  task automatic test_overflow();
    send_op(make_op(1, 0, 0, 0, 0, 0, 0));
    for (int i = 0; i < 36; i++)
      send_op(make_op(0, 1, $urandom_range(63), 1, $urandom_range(63),
                      1, $urandom_range(63)));
    for (int i = 0; i < 66; i++) send_op(make_op(0, 0, 0, 0, 0, 0, 0));
  endtask

  // Create every slot, run out, then recover through a release
  task automatic test_exhaustion();
    send_op(make_op(1, 0, 0, 0, 0, 0, 0));
    for (int i = 0; i < 66; i++) send_op(make_op(0, 0, 0, 0, 0, 0, 0));
    send_op(make_op(0, 0, 0, 1, 17, 0, 0));
    send_op(make_op(0, 0, 0, 0, 0, 0, 0));
    send_op(make_op(0, 1, 63, 1, 0, 0, 0));
  endtask

  // Bursts of operations with a release mix that grows, balances or fills the list
  task automatic test_random(input int unsigned n_ops, input int unsigned idle_pct,
                             input int unsigned stall_pct);
    burst_mix_e  mix;
    int unsigned left_in_burst;
    int unsigned rel_pct;
    bit          st;
    src_idle_pct   = idle_pct;
    sink_stall_pct = stall_pct;
    left_in_burst  = 0;
    mix            = MIX_EVEN;
    for (int unsigned i = 0; i < n_ops; i++) begin
      st = ($urandom_range(99) < 2);
      if (left_in_burst == 0) begin
        left_in_burst = $urandom_range(60, 10);
        mix = burst_mix_e'($urandom_range(2));
        st  = ($urandom_range(3) == 0);
      end
      left_in_burst--;
      case (mix)
        MIX_GROW: rel_pct = 10;
        MIX_FILL: rel_pct = 70;
        default:  rel_pct = 33;
      endcase
      send_op(make_op(st, $urandom_range(99) < rel_pct, $urandom_range(63),
                      $urandom_range(99) < rel_pct, $urandom_range(63),
                      $urandom_range(99) < rel_pct, $urandom_range(63)));
    end
  endtask

  initial begin
    rst_ni         <= 1'b0;
    s_axis_tvalid  <= 1'b0;
    s_axis_tdata   <= '0;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    mismatches     = 0;
    ring_head      = 0;
    ring_tail      = 0;
    ring_count     = 0;
    created        = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    src_idle_pct   = 33;
    sink_stall_pct = 33;
    test_overflow();
    test_exhaustion();
    test_random(150, 0, 0);
    test_random(150, 59, 0);
    test_random(150, 0, 59);
    test_random(150, 33, 33);

    s_axis_tvalid <= 1'b0;
    while (pending_grants.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
